// ===== rtl/core/bump_and_turn_walk_controller_core_defines.svh =====
// Assertion macros for the bump-and-turn walk controller core.
// Used by the top level; needs clk and rst in scope.
`ifndef BUMP_AND_TURN_WALK_CONTROLLER_CORE_DEFINES_SVH
`define BUMP_AND_TURN_WALK_CONTROLLER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define BAT_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition at one edge implies a condition at the next.
`define BAT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/bat_pkg.sv =====
// Shared types, codes and constants of the bump-and-turn walk controller.
// No dependencies.
package bat_pkg;

  localparam int VELOCITY_WIDTH_DEFAULT   = 16;
  localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

  localparam int CMD_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 40;

  localparam logic [1:0] MODE_BUMPER = 2'd0;
  localparam logic [1:0] MODE_CLIFF  = 2'd1;
  localparam logic [1:0] MODE_DROP   = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] SENSOR_LEFT  = 2'd0;
  localparam logic [1:0] SENSOR_RIGHT = 2'd2;

  localparam logic [1:0] COLOR_BLACK  = 2'd0;
  localparam logic [1:0] COLOR_ORANGE = 2'd1;
  localparam logic [1:0] COLOR_RED    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TURN_TICKS = 2'd2;

  localparam logic [15:0] FWD_SPEED_RESET       = 16'd500;
  localparam logic [14:0] TURN_RATE_RESET       = 15'd100;
  localparam logic [15:0] HALF_TURN_TICKS_RESET = 16'd314;

  typedef struct packed {
    logic        random_direction;
    logic [15:0] random_fraction;
    logic        active;
    logic [1:0]  sensor_index;
  } item_t;

  typedef struct packed {
    logic [15:0] angular_command;
    logic [15:0] linear_command;
    logic        command_valid;
    logic [1:0]  led2_color;
    logic        led2_write;
    logic [1:0]  led1_color;
    logic        led1_write;
  } result_t;

  typedef struct packed {
    logic signed [15:0] fwd_speed;
    logic [14:0]        turn_rate;
    logic [15:0]        half_turn_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] bumper_flags;
    logic [2:0] cliff_flags;
    logic [1:0] drop_flags;
    logic [2:0] led_marks;
    logic       stopped;
    logic       turn_requested;
    logic       turning_now;
    logic       turn_negative;
  } flags_t;

endpackage

// ===== rtl/core/bump_and_turn_walk_controller_core.sv =====
// Bump-and-turn walk controller core: input register, step logic, result register.
// Depends on bat_pkg, bat_step and the core defines header.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries sensor events
//   and control ticks; s_tuser selects the kind (bumper, cliff, wheel drop,
//   tick). Master stream (m_tvalid/m_tready/m_tdata) returns exactly one
//   result per item: LED writes and an optional velocity command.
//   Configuration writes arrive on cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register; the step logic fills the
//   result register from it when the result stage can advance, and m_tvalid
//   rises with it. Throughput is one item per cycle while m_tready stays high,
//   with combinational step logic (one 16x16 multiply for the turn length, then a compare).
// Reset: synchronous rst clears both stages, all flags and counters and
//   loads the register defaults (500, 100, 314).
// Stall: with m_tready low the result is held; the input register still
//   takes one more transaction, then s_tready drops until the result is taken.
`include "bump_and_turn_walk_controller_core_defines.svh"

module bump_and_turn_walk_controller_core
  import bat_pkg::*;
#(
  parameter int VELOCITY_WIDTH   = VELOCITY_WIDTH_DEFAULT,
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sensor_index[1:0], active[2], random_fraction[18:3], random_direction[19]
  input  logic [S_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // led1_write[0], led1_color[2:1], led2_write[3], led2_color[5:4],
  // command_valid[6], linear_command[22:7], angular_command[38:23]
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                        in_valid;
  logic [1:0]                  in_mode;
  item_t                       in_item;
  result_t                     out_result;
  cfg_t                        cfg;
  flags_t                      flags;
  flags_t                      flags_next;
  logic [TICK_COUNT_WIDTH-1:0] turn_length;
  logic [TICK_COUNT_WIDTH-1:0] turn_length_next;
  logic [TICK_COUNT_WIDTH-1:0] turn_elapsed;
  logic [TICK_COUNT_WIDTH-1:0] turn_elapsed_next;
  result_t                     step_result;
  logic                        advance;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_result};

  bat_step #(
    .VELOCITY_WIDTH   (VELOCITY_WIDTH),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_step (
    .mode              (in_mode),
    .item              (in_item),
    .cfg               (cfg),
    .flags             (flags),
    .turn_length       (turn_length),
    .turn_elapsed      (turn_elapsed),
    .flags_next        (flags_next),
    .turn_length_next  (turn_length_next),
    .turn_elapsed_next (turn_elapsed_next),
    .result            (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_speed       <= FWD_SPEED_RESET;
      cfg.turn_rate       <= TURN_RATE_RESET;
      cfg.half_turn_ticks <= HALF_TURN_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FWD_SPEED:       cfg.fwd_speed       <= cfg_data;
        REG_TURN_RATE:       cfg.turn_rate       <= cfg_data[14:0];
        REG_HALF_TURN_TICKS: cfg.half_turn_ticks <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_item <= item_t'(s_tdata[19:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      flags        <= '0;
      turn_length  <= '0;
      turn_elapsed <= '0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        flags        <= flags_next;
        turn_length  <= turn_length_next;
        turn_elapsed <= turn_elapsed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_result <= step_result;
    end
  end

  `BAT_ASSERT_HOLDS(a_stop_tracks_mark, flags.stopped == flags.led_marks[2],
    "stop flag and drop mark differ")
  `BAT_ASSERT_HOLDS(a_cmd_excludes_led,
    !m_tvalid || !(out_result.command_valid &&
    (out_result.led1_write || out_result.led2_write)),
    "command and LED write in one result")
  `BAT_ASSERT_HOLDS(a_ready_when_empty, m_tvalid || s_tready,
    "input blocked with empty result stage")
  `BAT_ASSERT_NEXT(a_tick_clears_request,
    advance && in_valid && in_mode == MODE_TICK && !flags.stopped,
    !flags.turn_requested, "turn request survived a running tick")

endmodule

// ===== rtl/core/bat_step.sv =====
// Next-state and result logic for one item of the walk controller.
// Depends on bat_pkg.
module bat_step
  import bat_pkg::*;
#(
  parameter int VELOCITY_WIDTH   = VELOCITY_WIDTH_DEFAULT,
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
  input  logic [1:0]                  mode,
  input  item_t                       item,
  input  cfg_t                        cfg,
  input  flags_t                      flags,
  input  logic [TICK_COUNT_WIDTH-1:0] turn_length,
  input  logic [TICK_COUNT_WIDTH-1:0] turn_elapsed,
  output flags_t                      flags_next,
  output logic [TICK_COUNT_WIDTH-1:0] turn_length_next,
  output logic [TICK_COUNT_WIDTH-1:0] turn_elapsed_next,
  output result_t                     result
);

  localparam int LEN_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;
  localparam int CW    = (VELOCITY_WIDTH > CMD_W) ? VELOCITY_WIDTH : CMD_W;
  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = {TICK_COUNT_WIDTH{1'b1}};

  logic [31:0]                 product;
  logic [LEN_W-1:0]            len_wide;
  logic [TICK_COUNT_WIDTH-1:0] new_length;
  logic [VELOCITY_WIDTH-1:0]   ang_mag;
  logic [VELOCITY_WIDTH-1:0]   ang_vel;
  logic [VELOCITY_WIDTH-1:0]   lin_vel;

  assign product  = 32'(item.random_fraction) * 32'(cfg.half_turn_ticks);
  assign len_wide = LEN_W'(product[31:16]);
  assign new_length = (len_wide > LEN_W'(TICK_MAX)) ? TICK_MAX
                                                   : TICK_COUNT_WIDTH'(len_wide);
  assign ang_mag = VELOCITY_WIDTH'(cfg.turn_rate);
  assign lin_vel = VELOCITY_WIDTH'(cfg.fwd_speed);

  always_comb begin
    flags_next        = flags;
    turn_length_next  = turn_length;
    turn_elapsed_next = turn_elapsed;
    result            = '0;
    ang_vel           = '0;
    case (mode)
      MODE_BUMPER: begin
        if (item.active) flags_next.turn_requested = 1'b1;
        if (item.sensor_index <= SENSOR_RIGHT)
          flags_next.bumper_flags[item.sensor_index] = item.active;
        if (!flags.led_marks[0] && flags_next.bumper_flags != 3'd0) begin
          flags_next.led_marks[0] = 1'b1;
          result.led1_write       = 1'b1;
          result.led1_color       = COLOR_ORANGE;
        end else if (flags.led_marks[0] && flags_next.bumper_flags == 3'd0) begin
          flags_next.led_marks[0] = 1'b0;
          result.led1_write       = 1'b1;
          result.led1_color       = COLOR_BLACK;
        end
      end
      MODE_CLIFF: begin
        if (item.active) flags_next.turn_requested = 1'b1;
        if (item.sensor_index <= SENSOR_RIGHT)
          flags_next.cliff_flags[item.sensor_index] = item.active;
        if (!flags.led_marks[1] && flags_next.cliff_flags != 3'd0) begin
          flags_next.led_marks[1] = 1'b1;
          result.led2_write       = 1'b1;
          result.led2_color       = COLOR_ORANGE;
        end else if (flags.led_marks[1] && flags_next.cliff_flags == 3'd0) begin
          flags_next.led_marks[1] = 1'b0;
          result.led2_write       = 1'b1;
          result.led2_color       = COLOR_BLACK;
        end
      end
      MODE_DROP: begin
        if (item.sensor_index == SENSOR_LEFT) flags_next.drop_flags[0] = item.active;
        if (item.sensor_index == SENSOR_RIGHT) flags_next.drop_flags[1] = item.active;
        if (!flags.led_marks[2] && flags_next.drop_flags != 2'd0) begin
          flags_next.led_marks[2] = 1'b1;
          flags_next.stopped      = 1'b1;
          result.led1_write       = 1'b1;
          result.led1_color       = COLOR_RED;
          result.led2_write       = 1'b1;
          result.led2_color       = COLOR_RED;
        end else if (flags.led_marks[2] && flags_next.drop_flags == 2'd0) begin
          flags_next.led_marks[2] = 1'b0;
          flags_next.stopped      = 1'b0;
          result.led1_write       = 1'b1;
          result.led1_color       = COLOR_BLACK;
          result.led2_write       = 1'b1;
          result.led2_color       = COLOR_BLACK;
        end
      end
      MODE_TICK: begin
        if (flags.stopped) begin
          result.command_valid = 1'b1;
          if (flags.turning_now && turn_elapsed != TICK_MAX)
            turn_elapsed_next = turn_elapsed + TICK_COUNT_WIDTH'(1);
        end else begin
          if (flags.turn_requested) begin
            flags_next.turn_requested = 1'b0;
            flags_next.turning_now    = 1'b1;
            flags_next.turn_negative  = !item.random_direction;
            turn_length_next          = new_length;
            turn_elapsed_next         = '0;
          end
          if (flags_next.turning_now) begin
            if (turn_elapsed_next < turn_length_next) begin
              result.command_valid = 1'b1;
              ang_vel = flags_next.turn_negative ? (VELOCITY_WIDTH'(0) - ang_mag)
                                                 : ang_mag;
              if (turn_elapsed_next != TICK_MAX)
                turn_elapsed_next = turn_elapsed_next + TICK_COUNT_WIDTH'(1);
            end else begin
              flags_next.turning_now = 1'b0;
            end
          end else begin
            result.command_valid  = 1'b1;
            result.linear_command = CMD_W'(CW'(lin_vel));
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
    result.angular_command = CMD_W'(CW'(ang_vel));
  end

endmodule

// ===== bench/bump_and_turn_walk_controller_core_tb.sv =====
// Self-checking bench for the bump-and-turn walk controller core: directed sensor
// and tick sequences, then random phases under several register settings and idling mixes.
// Depends on bat_pkg and the core RTL; results are predicted by a ledger class.
module bump_and_turn_walk_controller_core_tb;
  import bat_pkg::*;

  class walk_ledger;
    logic signed [15:0] lin_vel;
    logic [14:0]        ang_vel;
    logic [15:0]        half_ticks;
    logic [2:0]         bumpers;
    logic [2:0]         cliffs;
    logic [1:0]         drops;
    logic [2:0]         marks;
    bit                 halted;
    bit                 turn_pending;
    bit                 turning;
    bit                 turn_neg;
    logic [15:0]        turn_len;
    logic [15:0]        elapsed;
    result_t            due_results[$];
    int                 failures;

    function new();
      lin_vel = FWD_SPEED_RESET;
      ang_vel = TURN_RATE_RESET;
      half_ticks = HALF_TURN_TICKS_RESET;
      bumpers = '0;
      cliffs = '0;
      drops = '0;
      marks = '0;
      halted = 0;
      turn_pending = 0;
      turning = 0;
      turn_neg = 0;
      turn_len = '0;
      elapsed = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_FWD_SPEED: lin_vel = data;
        REG_TURN_RATE: ang_vel = data[14:0];
        REG_HALF_TURN_TICKS: half_ticks = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void take_item(logic [1:0] mode, item_t it);
      result_t     r;
      logic [2:0]  fl;
      logic [31:0] prod;
      logic        w;
      logic [1:0]  c;
      int          m;
      r = '0;
      w = 0;
      c = COLOR_BLACK;
      if (mode == MODE_BUMPER || mode == MODE_CLIFF) begin
        if (it.active)
          turn_pending = 1;
        if (it.sensor_index != 2'd3) begin
          if (mode == MODE_BUMPER)
            bumpers[it.sensor_index] = it.active;
          else
            cliffs[it.sensor_index] = it.active;
        end
        fl = (mode == MODE_BUMPER) ? bumpers : cliffs;
        m = (mode == MODE_BUMPER) ? 0 : 1;
        if (!marks[m] && fl != 0) begin
          marks[m] = 1;
          w = 1;
          c = COLOR_ORANGE;
        end else if (marks[m] && fl == 0) begin
          marks[m] = 0;
          w = 1;
          c = COLOR_BLACK;
        end
        if (mode == MODE_BUMPER) begin
          r.led1_write = w;
          r.led1_color = c;
        end else begin
          r.led2_write = w;
          r.led2_color = c;
        end
      end else if (mode == MODE_DROP) begin
        if (it.sensor_index == SENSOR_LEFT)
          drops[0] = it.active;
        else if (it.sensor_index == SENSOR_RIGHT)
          drops[1] = it.active;
        if (!marks[2] && drops != 0) begin
          marks[2] = 1;
          halted = 1;
          r.led1_write = 1;
          r.led2_write = 1;
          r.led1_color = COLOR_RED;
          r.led2_color = COLOR_RED;
        end else if (marks[2] && drops == 0) begin
          marks[2] = 0;
          halted = 0;
          r.led1_write = 1;
          r.led2_write = 1;
          r.led1_color = COLOR_BLACK;
          r.led2_color = COLOR_BLACK;
        end
      end else begin
        if (halted) begin
          r.command_valid = 1;
          if (turning && elapsed != 16'hFFFF)
            elapsed = elapsed + 16'd1;
        end else begin
          if (turn_pending) begin
            prod = {16'd0, it.random_fraction} * {16'd0, half_ticks};
            turn_len = prod[31:16];
            turn_neg = !it.random_direction;
            elapsed = '0;
            turning = 1;
            turn_pending = 0;
          end
          if (turning) begin
            if (elapsed < turn_len) begin
              r.command_valid = 1;
              r.angular_command = turn_neg ? 16'd0 - {1'b0, ang_vel} : {1'b0, ang_vel};
              if (elapsed != 16'hFFFF)
                elapsed = elapsed + 16'd1;
            end else begin
              turning = 0;
            end
          end else begin
            r.command_valid = 1;
            r.linear_command = lin_vel;
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s expected %0h actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result %h", got);
        failures++;
        return;
      end
      want = due_results.pop_front();
      compare("led1_write", want.led1_write, got.led1_write);
      compare("led1_color", want.led1_color, got.led1_color);
      compare("led2_write", want.led2_write, got.led2_write);
      compare("led2_color", want.led2_color, got.led2_color);
      compare("command_valid", want.command_valid, got.command_valid);
      compare("linear_command", want.linear_command, got.linear_command);
      compare("angular_command", want.angular_command, got.angular_command);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  walk_ledger ledger;
  int         src_idle_pct;
  int         sink_stall_pct;

  bump_and_turn_walk_controller_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      ledger.match_result(m_tdata[$bits(result_t)-1:0]);
  end

  initial begin
    #3000000;
    $display("bump_and_turn_walk_controller_core_tb NOT OK");
    $finish;
  end

  function automatic item_t make_item(logic [1:0] idx, logic act, logic [15:0] frac,
                                      logic dir);
    item_t it;
    it.sensor_index = idx;
    it.active = act;
    it.random_fraction = frac;
    it.random_direction = dir;
    return it;
  endfunction

  task automatic send_item(input logic [1:0] mode, input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {{(S_DATA_W - $bits(item_t)){1'b0}}, it};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    ledger.take_item(mode, it);
    @(negedge clk);
  endtask

  task automatic sense(input logic [1:0] mode, input logic [1:0] idx, input logic act);
    send_item(mode, make_item(idx, act, 16'($urandom), 1'($urandom)));
  endtask

  task automatic tick(input logic [15:0] frac, input logic dir);
    send_item(MODE_TICK, make_item(2'($urandom), 1'($urandom), frac, dir));
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 0;
    while (ledger.pending() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    ledger.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic draw_item(output logic [1:0] mode, output item_t it);
    int pick;
    pick = $urandom_range(99);
    it.random_fraction = 16'($urandom);
    it.random_direction = 1'($urandom);
    it.sensor_index = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    it.active = 1'($urandom);
    if (pick < 55) begin
      mode = MODE_TICK;
    end else if (pick < 72) begin
      mode = MODE_BUMPER;
    end else if (pick < 89) begin
      mode = MODE_CLIFF;
    end else begin
      mode = MODE_DROP;
      it.active = ($urandom_range(99) < 35);
    end
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
      default: begin src_idle_pct = 16; sink_stall_pct = 16; end
    endcase
  endtask

  initial begin
    logic [1:0] mode;
    item_t      it;
    ledger = new();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = MODE_BUMPER;
    cfg_valid = 0;
    cfg_index = REG_FWD_SPEED;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    tick(16'h1234, 1);
    sense(MODE_BUMPER, SENSOR_LEFT, 1);
    sense(MODE_BUMPER, SENSOR_RIGHT, 1);
    sense(MODE_BUMPER, SENSOR_LEFT, 0);
    sense(MODE_BUMPER, SENSOR_RIGHT, 0);
    sense(MODE_BUMPER, 2'd3, 1);
    sense(MODE_CLIFF, 2'd1, 1);
    tick(16'hFFFF, 1);
    tick(16'h0000, 0);
    sense(MODE_CLIFF, 2'd1, 0);
    sense(MODE_CLIFF, 2'd3, 0);
    sense(MODE_DROP, 2'd1, 1);
    sense(MODE_DROP, SENSOR_LEFT, 1);
    tick(16'hFFFF, 0);
    sense(MODE_DROP, SENSOR_RIGHT, 1);
    sense(MODE_DROP, SENSOR_LEFT, 0);
    sense(MODE_DROP, SENSOR_RIGHT, 0);
    sense(MODE_BUMPER, 2'd1, 1);
    tick(16'h0000, 1);
    tick(16'h5555, 1);
    sense(MODE_CLIFF, SENSOR_LEFT, 1);
    tick(16'h0200, 0);
    tick(16'hAAAA, 1);
    tick(16'h0000, 0);
    tick(16'hFFFF, 0);

    for (int phase = 0; phase < 5; phase++) begin
      hold_until_drained();
      repeat (4) @(negedge clk);
      case (phase)
        0: begin
          write_reg(REG_FWD_SPEED, 16'h7FFF);
          write_reg(REG_TURN_RATE, 16'hFFFF);
          write_reg(REG_HALF_TURN_TICKS, 16'h0000);
        end
        1: begin
          write_reg(REG_FWD_SPEED, 16'h8000);
          write_reg(REG_TURN_RATE, 16'h0000);
          write_reg(REG_HALF_TURN_TICKS, 16'hFFFF);
        end
        2: begin
          write_reg(REG_FWD_SPEED, 16'($urandom));
          write_reg(REG_TURN_RATE, 16'($urandom));
          write_reg(REG_HALF_TURN_TICKS, 16'($urandom_range(24, 1)));
          write_reg(2'd3, 16'($urandom));
        end
        3: begin
          write_reg(REG_FWD_SPEED, 16'd1);
          write_reg(REG_TURN_RATE, 16'd1);
          write_reg(REG_HALF_TURN_TICKS, 16'd6);
        end
        default: begin
          write_reg(REG_FWD_SPEED, 16'($urandom));
          write_reg(REG_TURN_RATE, TURN_RATE_RESET);
          write_reg(REG_HALF_TURN_TICKS, 16'($urandom_range(64, 1)));
        end
      endcase
      set_idling(phase);
      for (int i = 0; i < 250; i++) begin
        if (i == 120) begin
          hold_until_drained();
          @(negedge clk);
        end
        draw_item(mode, it);
        send_item(mode, it);
      end
    end

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (ledger.failures == 0)
      $display("bump_and_turn_walk_controller_core_tb OK");
    else
      $display("bump_and_turn_walk_controller_core_tb NOT OK");
    $finish;
  end

endmodule
